// ----- design/tra_pkg.sv -----
// Shared widths, constants and types of the tanh rational activation pipeline.
`default_nettype none
package tra_pkg;
   localparam int X_W    = 16;
   localparam int Y_W    = 16;
   localparam int AXF_W  = 17;
   localparam int AX_W   = 14;
   localparam int FRAC_W = 20;
   localparam int U_W    = 25;
   localparam int N1_W   = 29;
   localparam int N2_W   = 35;
   localparam int N3_W   = 40;
   localparam int D1_W   = 32;
   localparam int D2_W   = 38;
   localparam int D3_W   = 42;
   localparam int NUM_W  = 57;
   localparam int Q_W    = 15;
   localparam int MAG_W  = 15;
   localparam int PROD_W = 2 * MAG_W;
   localparam int SQ_SH  = 14;

   localparam logic [AXF_W-1:0]  SAT_LIMIT = 17'd10036;
   localparam logic [AXF_W-1:0]  X_WRAP    = 17'h10000;
   localparam logic [MAG_W-1:0]  MAG_ONE   = 15'd16384;
   localparam logic [Y_W-1:0]    Y_ONE     = 16'd16384;
   localparam logic [Y_W-1:0]    Y_ZERO    = 16'd0;
   localparam logic [PROD_W-1:0] SQ_ROUND  = 30'd8192;

   localparam logic [D1_W-1:0] D1_MUL = 32'd28;
   localparam logic [N1_W-1:0] N1_ADD = N1_W'(64'd378 << FRAC_W);
   localparam logic [N2_W-1:0] N2_ADD = N2_W'(64'd17325 << FRAC_W);
   localparam logic [N3_W-1:0] N3_ADD = N3_W'(64'd135135 << FRAC_W);
   localparam logic [D1_W-1:0] D1_ADD = D1_W'(64'd3150 << FRAC_W);
   localparam logic [D2_W-1:0] D2_ADD = D2_W'(64'd62370 << FRAC_W);
   localparam logic [D3_W-1:0] D3_ADD = D3_W'(64'd135135 << FRAC_W);

   localparam logic OP_TANH  = 1'b0;
   localparam logic OP_DERIV = 1'b1;

   typedef struct packed {
      logic opcode;
      logic neg;
      logic sat;
      logic zero;
      logic last;
   } side_type;
endpackage
`default_nettype wire

// ----- design/tra_front.sv -----
// Front pipeline: magnitude, threshold flags and Horner evaluation of both polynomials.
`default_nettype none
module tra_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic                       in_opcode,
   input  wire logic [tra_pkg::X_W-1:0]    in_x,
   input  wire logic                       in_last,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output logic [tra_pkg::NUM_W-1:0]       out_num,
   output logic [tra_pkg::D3_W-1:0]        out_den,
   output tra_pkg::side_type               out_side
);
   localparam int STAGES = 6;

   logic [STAGES-1:0] v_ff;
   logic [STAGES:0]   rdy;

   logic [tra_pkg::AXF_W-1:0]     ax_full;
   logic [2*tra_pkg::AX_W-1:0]    sq_prod;
   logic [tra_pkg::U_W+tra_pkg::N1_W-1:0] pn1;
   logic [tra_pkg::U_W+tra_pkg::D1_W-1:0] pd1;
   logic [tra_pkg::U_W+tra_pkg::N2_W-1:0] pn2;
   logic [tra_pkg::U_W+tra_pkg::D2_W-1:0] pd2;
   logic [tra_pkg::AX_W+tra_pkg::N3_W-1:0] pnum;

   logic [tra_pkg::AX_W-1:0] ax1_ff, ax2_ff, ax3_ff, ax4_ff, ax5_ff;
   logic [tra_pkg::U_W-1:0]  u2_ff, u3_ff, u4_ff;
   logic [tra_pkg::N1_W-1:0] n1_ff;
   logic [tra_pkg::D1_W-1:0] d1_ff;
   logic [tra_pkg::N2_W-1:0] n2_ff;
   logic [tra_pkg::D2_W-1:0] d2_ff;
   logic [tra_pkg::N3_W-1:0] n3_ff;
   logic [tra_pkg::D3_W-1:0] d3_ff, den6_ff;
   logic [tra_pkg::NUM_W-1:0] num6_ff;
   tra_pkg::side_type side1_ff, side2_ff, side3_ff, side4_ff, side5_ff, side6_ff;
   tra_pkg::side_type side_in;

   always_comb begin
      rdy[STAGES] = out_ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   assign in_ready = rdy[0];

   always_comb begin
      ax_full = in_x[tra_pkg::X_W-1] ? (tra_pkg::X_WRAP - tra_pkg::AXF_W'(in_x))
                                     : tra_pkg::AXF_W'(in_x);
      side_in.opcode = in_opcode;
      side_in.neg    = in_x[tra_pkg::X_W-1];
      side_in.sat    = ax_full >= tra_pkg::SAT_LIMIT;
      side_in.zero   = in_x == '0;
      side_in.last   = in_last;
   end

   assign sq_prod = ax1_ff * ax1_ff;
   assign pn1     = u3_ff * n1_ff;
   assign pd1     = u3_ff * d1_ff;
   assign pn2     = u4_ff * n2_ff;
   assign pd2     = u4_ff * d2_ff;
   assign pnum    = ax5_ff * n3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         ax1_ff   <= ax_full[tra_pkg::AX_W-1:0];
         side1_ff <= side_in;
      end
      if (rdy[1]) begin
         u2_ff    <= sq_prod[tra_pkg::U_W+1:2];
         ax2_ff   <= ax1_ff;
         side2_ff <= side1_ff;
      end
      if (rdy[2]) begin
         n1_ff    <= tra_pkg::N1_W'(u2_ff) + tra_pkg::N1_ADD;
         d1_ff    <= tra_pkg::D1_W'(u2_ff) * tra_pkg::D1_MUL + tra_pkg::D1_ADD;
         u3_ff    <= u2_ff;
         ax3_ff   <= ax2_ff;
         side3_ff <= side2_ff;
      end
      if (rdy[3]) begin
         n2_ff    <= tra_pkg::N2_W'(pn1 >> tra_pkg::FRAC_W) + tra_pkg::N2_ADD;
         d2_ff    <= tra_pkg::D2_W'(pd1 >> tra_pkg::FRAC_W) + tra_pkg::D2_ADD;
         u4_ff    <= u3_ff;
         ax4_ff   <= ax3_ff;
         side4_ff <= side3_ff;
      end
      if (rdy[4]) begin
         n3_ff    <= tra_pkg::N3_W'(pn2 >> tra_pkg::FRAC_W) + tra_pkg::N3_ADD;
         d3_ff    <= tra_pkg::D3_W'(pd2 >> tra_pkg::FRAC_W) + tra_pkg::D3_ADD;
         ax5_ff   <= ax4_ff;
         side5_ff <= side4_ff;
      end
      if (rdy[5]) begin
         num6_ff  <= tra_pkg::NUM_W'({pnum, 3'b000}) + tra_pkg::NUM_W'(d3_ff >> 1);
         den6_ff  <= d3_ff;
         side6_ff <= side5_ff;
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_num   = num6_ff;
   assign out_den   = den6_ff;
   assign out_side  = side6_ff;
endmodule
`default_nettype wire

// ----- design/tra_div.sv -----
// Restoring divider, one quotient bit per pipeline stage.
`default_nettype none
module tra_div (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic [tra_pkg::NUM_W-1:0] in_num,
   input  wire logic [tra_pkg::D3_W-1:0]  in_den,
   input  wire tra_pkg::side_type         in_side,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic [tra_pkg::Q_W-1:0]        out_q,
   output tra_pkg::side_type              out_side
);
   localparam int STAGES = tra_pkg::Q_W;

   logic                      v_ff    [STAGES];
   logic [tra_pkg::NUM_W-1:0] rem_ff  [STAGES];
   logic [tra_pkg::D3_W-1:0]  den_ff  [STAGES];
   logic [tra_pkg::Q_W-1:0]   q_ff    [STAGES];
   tra_pkg::side_type         side_ff [STAGES];
   logic [STAGES:0]           rdy;

   always_comb begin
      rdy[STAGES] = out_ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   assign in_ready = rdy[0];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      localparam int SH = STAGES - 1 - k;
      logic                      v_prev;
      logic [tra_pkg::NUM_W-1:0] rem_prev;
      logic [tra_pkg::D3_W-1:0]  den_prev;
      logic [tra_pkg::Q_W-1:0]   q_prev;
      tra_pkg::side_type         side_prev;
      logic [tra_pkg::NUM_W-1:0] trial;
      logic                      take;

      if (k == 0) begin : g_head
         assign v_prev    = in_valid;
         assign rem_prev  = in_num;
         assign den_prev  = in_den;
         assign q_prev    = '0;
         assign side_prev = in_side;
      end else begin : g_body
         assign v_prev    = v_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign q_prev    = q_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      assign trial = tra_pkg::NUM_W'(den_prev) << SH;
      assign take  = rem_prev >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            rem_ff[k]  <= take ? (rem_prev - trial) : rem_prev;
            den_ff[k]  <= den_prev;
            q_ff[k]    <= q_prev | (tra_pkg::Q_W'(take) << SH);
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_q     = q_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];
endmodule
`default_nettype wire

// ----- design/tra_back.sv -----
// Back pipeline: cap and saturation, derivative square and the output register.
`default_nettype none
module tra_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire logic [tra_pkg::Q_W-1:0]  in_q,
   input  wire tra_pkg::side_type        in_side,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output logic [tra_pkg::Y_W-1:0]       out_y,
   output logic                         out_last
);
   logic va_ff, vb_ff;
   logic rdy_a, rdy_b;
   logic [tra_pkg::MAG_W-1:0]  mag_in, mag_ff;
   logic [tra_pkg::PROD_W-1:0] prod_ff;
   tra_pkg::side_type          side_a_ff;
   logic [tra_pkg::PROD_W-1:0] sq_round;
   logic [tra_pkg::Y_W-1:0]    y_in, y_ff;
   logic                       last_ff;

   assign rdy_b    = !vb_ff || out_ready;
   assign rdy_a    = !va_ff || rdy_b;
   assign in_ready = rdy_a;

   always_comb begin
      if (in_side.sat || (tra_pkg::MAG_W'(in_q) > tra_pkg::MAG_ONE)
          || (in_q > tra_pkg::Q_W'(tra_pkg::MAG_ONE))) begin
         mag_in = tra_pkg::MAG_ONE;
      end else begin
         mag_in = tra_pkg::MAG_W'(in_q);
      end
   end

   always_comb begin
      sq_round = (prod_ff + tra_pkg::SQ_ROUND) >> tra_pkg::SQ_SH;
      if (side_a_ff.opcode == tra_pkg::OP_TANH) begin
         y_in = side_a_ff.neg ? (tra_pkg::Y_ZERO - tra_pkg::Y_W'(mag_ff))
                              : tra_pkg::Y_W'(mag_ff);
      end else if (side_a_ff.zero) begin
         y_in = tra_pkg::Y_ONE;
      end else if (side_a_ff.sat) begin
         y_in = tra_pkg::Y_ZERO;
      end else begin
         y_in = tra_pkg::Y_ONE - tra_pkg::Y_W'(sq_round);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (rdy_a) begin
            va_ff <= in_valid;
         end
         if (rdy_b) begin
            vb_ff <= va_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a) begin
         mag_ff    <= mag_in;
         prod_ff   <= mag_in * mag_in;
         side_a_ff <= in_side;
      end
      if (rdy_b) begin
         y_ff    <= y_in;
         last_ff <= side_a_ff.last;
      end
   end

   assign out_valid = vb_ff;
   assign out_y     = y_ff;
   assign out_last  = last_ff;

   a_deriv_zero : assert property (@(posedge clock) disable iff (reset)
      (va_ff && rdy_b && side_a_ff.opcode == tra_pkg::OP_DERIV && side_a_ff.zero)
      |=> (y_ff == tra_pkg::Y_ONE))
      else $error("derivative at zero is not one");

   a_tanh_sat : assert property (@(posedge clock) disable iff (reset)
      (va_ff && rdy_b && side_a_ff.opcode == tra_pkg::OP_TANH && side_a_ff.sat)
      |=> (y_ff == tra_pkg::Y_ONE || y_ff == (tra_pkg::Y_ZERO - tra_pkg::Y_ONE)))
      else $error("saturated tanh is not plus or minus one");

   a_y_range : assert property (@(posedge clock) disable iff (reset)
      vb_ff |-> ($signed(y_ff) <= $signed(tra_pkg::Y_ONE)
                 && $signed(y_ff) >= -$signed(tra_pkg::Y_ONE)))
      else $error("result beyond unit range");
endmodule
`default_nettype wire

// ----- design/tanh_rational_activation_top.sv -----
// Top level of the tanh rational activation pipeline.
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  request | req_valid req_ready req_opcode req_x_value   | in
//          | req_last_in                                  |
//  result  | rsp_valid rsp_ready rsp_y_value rsp_last_out | out
//
// One beat enters per cycle unless a stalled output backs up the pipeline.
// Six front, fifteen divider (one quotient bit each) and two back stages.
// Reset clears only the stage valid bits; the pipeline is empty afterwards.
// Each stage holds while its successor is full and stalled; empty stages
// still fill, so beats keep entering while a result waits at the output.
`default_nettype none
module tanh_rational_activation_top (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_opcode,
   input  wire logic [tra_pkg::X_W-1:0]  req_x_value,
   input  wire logic                    req_last_in,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [tra_pkg::Y_W-1:0]       rsp_y_value,
   output logic                         rsp_last_out
);
   logic                       f_valid, f_ready;
   logic [tra_pkg::NUM_W-1:0]  f_num;
   logic [tra_pkg::D3_W-1:0]   f_den;
   tra_pkg::side_type          f_side;
   logic                       d_valid, d_ready;
   logic [tra_pkg::Q_W-1:0]    d_q;
   tra_pkg::side_type          d_side;

   tra_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_opcode (req_opcode),
      .in_x      (req_x_value),
      .in_last   (req_last_in),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_num   (f_num),
      .out_den   (f_den),
      .out_side  (f_side)
   );

   tra_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_num    (f_num),
      .in_den    (f_den),
      .in_side   (f_side),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_q     (d_q),
      .out_side  (d_side)
   );

   tra_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .in_ready  (d_ready),
      .in_q      (d_q),
      .in_side   (d_side),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_y     (rsp_y_value),
      .out_last  (rsp_last_out)
   );
endmodule
`default_nettype wire

// ----- tb/tanh_rational_activation_top_tb.sv -----
// Self-checking testbench of the tanh rational activation pipeline.
`default_nettype none
module tanh_rational_activation_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [tra_pkg::Y_W-1:0] y_value;
      logic                    last_out;
   } tanh_result_type;

   class tanh_scoreboard;
      tanh_result_type pending[$];
      int              errors;

      function new();
         errors = 0;
      endfunction

      function logic [14:0] tanh_mag(logic [16:0] ax);
         logic [63:0] u, n, d, q;
         u = (64'(ax) * 64'(ax)) >> 2;
         if (64'(ax) * 10 >= 64'd100352) return 15'd16384;
         n = u + (64'd378 << 20);
         n = ((u * n) >> 20) + (64'd17325 << 20);
         n = ((u * n) >> 20) + (64'd135135 << 20);
         d = 28 * u + (64'd3150 << 20);
         d = ((u * d) >> 20) + (64'd62370 << 20);
         d = ((u * d) >> 20) + (64'd135135 << 20);
         q = (64'(ax) * n * 8 + (d >> 1)) / d;
         if (q > 64'd16384) q = 64'd16384;
         return q[14:0];
      endfunction

      function void note_sample(logic op, logic [15:0] x, logic last);
         logic        neg;
         logic [16:0] ax;
         logic [31:0] mag, sq;
         logic [15:0] y;
         tanh_result_type r;
         neg = x[15];
         ax  = neg ? (17'h10000 - 17'(x)) : 17'(x);
         mag = 32'(tanh_mag(ax));
         if (op == tra_pkg::OP_TANH) y = neg ? 16'(-mag) : mag[15:0];
         else if (ax == 0) y = tra_pkg::Y_ONE;
         else if (32'(ax) * 10 > 32'd100352) y = tra_pkg::Y_ZERO;
         else begin
            sq = (mag * mag + 32'd8192) >> 14;
            y  = 16'(32'd16384 - sq);
         end
         r.y_value  = y;
         r.last_out = last;
         pending.push_back(r);
      endfunction

      function void check_result(logic [15:0] y, logic last);
         tanh_result_type e;
         if (pending.size() == 0) begin
            $error("unexpected beat y_value=%0d", $signed(y));
            errors++;
            return;
         end
         e = pending.pop_front();
         if (y !== e.y_value) begin
            $error("y_value expected %0d actual %0d", $signed(e.y_value), $signed(y));
            errors++;
         end
         if (last !== e.last_out) begin
            $error("last_out expected %0b actual %0b", e.last_out, last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_opcode = 0, req_last_in = 0, rsp_ready = 0;
   logic [tra_pkg::X_W-1:0] req_x_value = '0;
   logic req_ready, rsp_valid, rsp_last_out;
   logic [tra_pkg::Y_W-1:0] rsp_y_value;
   int   send_idle = 0, stall_pct = 0;
   longint cycles = 0;
   tanh_scoreboard sb = new();

   tanh_rational_activation_top dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && req_valid && req_ready) sb.note_sample(req_opcode, req_x_value, req_last_in);
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_y_value, rsp_last_out);
      if (cycles > 400000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(negedge clock) rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= stall_pct);

   task automatic send_sample(logic op, logic [15:0] x, logic last);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_opcode <= op;
      req_x_value <= x;
      req_last_in <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_x();
      case ($urandom_range(3))
         0: return 16'($signed($urandom_range(20000)) - 10000);
         1: return 16'($signed($urandom_range(400)) - 200 + ($urandom_range(1) ? 10035 : -10035));
         default: return 16'($urandom);
      endcase
   endfunction

   logic [15:0] corner_x [12] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
      16'd10035, 16'd10036, -16'sd10035, -16'sd10036, 16'd2048, -16'sd2048, 16'd10037};

   initial begin
      repeat (10) @(negedge clock);
      reset <= 0;
      foreach (corner_x[i]) begin
         send_sample(tra_pkg::OP_TANH, corner_x[i], i[0]);
         send_sample(tra_pkg::OP_DERIV, corner_x[i], !i[0]);
      end
      for (int ph = 0; ph < 4; ph++) begin
         send_idle = (ph == 1 || ph == 3) ? 70 : 0;
         stall_pct = (ph == 2 || ph == 3) ? 70 : 0;
         if (ph == 3) begin
            send_idle = 21;
            stall_pct = 21;
         end
         repeat (270) send_sample($urandom_range(1), pick_x(), $urandom_range(7) == 0);
      end
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire
